>>> hw/rtl/acs_pkg.sv
`default_nettype none

package acs_pkg;

    // data-processing opcodes
    localparam logic [3:0] OPC_MOV = 4'hD;
    localparam logic [3:0] OPC_MVN = 4'hF;
    localparam logic [3:0] OPC_ORR = 4'hC;
    localparam logic [3:0] OPC_SUB = 4'h2;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;

    // microprogram addresses
    localparam t_step ST_FETCH  = 3'd0;
    localparam t_step ST_SINGLE = 3'd1;
    localparam t_step ST_COUNT  = 3'd2;
    localparam t_step ST_SELECT = 3'd3;
    localparam t_step ST_EMIT   = 3'd4;

    typedef enum logic [2:0] {
        ACT_LOAD,
        ACT_SINGLE,
        ACT_COUNT,
        ACT_SELECT,
        ACT_EMIT
    } t_act;

    typedef struct packed {
        t_act  act;
        t_step tgt_done;
        t_step tgt_else;
    } t_uword;

    // control store
    function automatic t_uword acs_rom(input t_step addr);
        t_uword w;
        case (addr)
            ST_FETCH:  w = '{act: ACT_LOAD,   tgt_done: ST_SINGLE, tgt_else: ST_FETCH};
            ST_SINGLE: w = '{act: ACT_SINGLE, tgt_done: ST_FETCH,  tgt_else: ST_COUNT};
            ST_COUNT:  w = '{act: ACT_COUNT,  tgt_done: ST_SELECT, tgt_else: ST_COUNT};
            ST_SELECT: w = '{act: ACT_SELECT, tgt_done: ST_EMIT,   tgt_else: ST_EMIT};
            ST_EMIT:   w = '{act: ACT_EMIT,   tgt_done: ST_FETCH,  tgt_else: ST_EMIT};
            default:   w = '{act: ACT_LOAD,   tgt_done: ST_FETCH,  tgt_else: ST_FETCH};
        endcase
        return w;
    endfunction

    function automatic logic [31:0] make_word(
        input logic [7:0] imm8,
        input logic [3:0] rotf,
        input logic [3:0] rd,
        input logic [3:0] rn,
        input logic [3:0] opc,
        input logic [3:0] cond
    );
        return {cond, 2'b00, 1'b1, opc, 1'b0, rn, rd, rotf, imm8};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/arm_constant_synthesizer.sv
`default_nettype none

// The request is taken in the fetch step. A constant that fits one MOV/MVN is emitted from the
//   single step; otherwise the count, select and emit steps follow.
// The value and its inverse each take at most four chunks, so at most four words are emitted;
//   the count step peels one chunk per operand per cycle. A new constant is taken only when
//   the sequencer is back at fetch; o_stall is high in every other step.
// Reset (synchronous, active low) returns the sequencer to fetch and drops o_valid.
module arm_constant_synthesizer
    import acs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_constant_value,
    input  wire logic [3:0]  i_dest_register,
    input  wire logic [3:0]  i_condition_code,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [31:0] o_instruction_word,
    output logic             o_last_word
);

    t_step       r_step, n_step;
    t_uword      uw;
    logic [31:0] r_val, r_inv, r_a, r_b;
    logic [3:0]  r_rd, r_cond;
    logic [2:0]  r_cnt_a, r_cnt_b;
    logic        r_mvn, r_first;
    logic        r_ovalid, r_olast;
    logic [31:0] r_oword;

    logic        in_acc, out_free, done, hold, load_out;
    logic [31:0] out_word;
    logic        out_last;

    logic [7:0]  a_imm8, b_imm8;
    logic [3:0]  a_rotf, b_rotf;
    logic [31:0] a_rest, b_rest;

    logic [7:0]  e_imm8;
    logic [3:0]  e_rotf;
    logic [31:0] e_rest;

    logic        sg_match, sg_mvn;
    logic [7:0]  sg_imm8;
    logic [3:0]  sg_rotf;

    acs_chunk u_chunk_a (.i_value(r_a), .o_imm8(a_imm8), .o_rotf(a_rotf), .o_rest(a_rest));
    acs_chunk u_chunk_b (.i_value(r_b), .o_imm8(b_imm8), .o_rotf(b_rotf), .o_rest(b_rest));

    assign uw       = acs_rom(r_step);
    assign o_stall  = (r_step != ST_FETCH);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    // emit peels the value operand, or the inverse operand on the MVN/SUB path
    assign e_imm8 = r_mvn ? b_imm8 : a_imm8;
    assign e_rotf = r_mvn ? b_rotf : a_rotf;
    assign e_rest = r_mvn ? b_rest : a_rest;

    // single rotated-immediate search, lowest rotation first, MOV before MVN
    always_comb begin
        logic [31:0] mask;
        logic        fit_v, fit_n;
        sg_match = 1'b0;
        sg_mvn   = 1'b0;
        sg_imm8  = 8'd0;
        sg_rotf  = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            mask  = 32'(({32'h0000_00FF, 32'h0000_00FF} >> (2 * i)));
            fit_v = (r_val & ~mask) == 32'd0;
            fit_n = (r_inv & ~mask) == 32'd0;
            if (fit_v || fit_n) begin
                sg_match = 1'b1;
                sg_mvn   = !fit_v;
                sg_rotf  = 4'(i);
                sg_imm8  = fit_v ? 8'(({r_val, r_val} << (2 * i)) >> 32)
                                 : 8'(({r_inv, r_inv} << (2 * i)) >> 32);
            end
        end
    end

    always_comb begin
        done     = 1'b0;
        hold     = 1'b0;
        load_out = 1'b0;
        out_word = 32'd0;
        out_last = 1'b1;
        case (uw.act)
            ACT_LOAD: begin
                done = in_acc;
            end
            ACT_SINGLE: begin
                done     = sg_match;
                hold     = sg_match && !out_free;
                load_out = sg_match && out_free;
                out_word = make_word(sg_imm8, sg_rotf, r_rd, 4'd0,
                                     sg_mvn ? OPC_MVN : OPC_MOV, r_cond);
            end
            ACT_COUNT: begin
                done = (a_rest == 32'd0) && (b_rest == 32'd0);
            end
            ACT_SELECT: begin
                done = 1'b1;
            end
            ACT_EMIT: begin
                done     = (e_rest == 32'd0);
                hold     = !out_free;
                load_out = out_free;
                out_last = (e_rest == 32'd0);
                out_word = make_word(e_imm8, e_rotf, r_rd, r_first ? 4'd0 : r_rd,
                                     r_first ? (r_mvn ? OPC_MVN : OPC_MOV)
                                             : (r_mvn ? OPC_SUB : OPC_ORR),
                                     r_cond);
            end
            default: begin
                done = 1'b0;
            end
        endcase
        n_step = hold ? r_step : (done ? uw.tgt_done : uw.tgt_else);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= ST_FETCH;
            r_ovalid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_oword <= out_word;
            r_olast <= out_last;
        end
        case (uw.act)
            ACT_LOAD: begin
                if (in_acc) begin
                    r_val   <= i_constant_value;
                    r_inv   <= ~i_constant_value;
                    r_a     <= i_constant_value;
                    r_b     <= ~i_constant_value;
                    r_rd    <= i_dest_register;
                    r_cond  <= i_condition_code;
                    r_cnt_a <= 3'd0;
                    r_cnt_b <= 3'd0;
                end
            end
            ACT_COUNT: begin
                if (r_a != 32'd0) begin
                    r_a     <= a_rest;
                    r_cnt_a <= r_cnt_a + 3'd1;
                end
                if (r_b != 32'd0) begin
                    r_b     <= b_rest;
                    r_cnt_b <= r_cnt_b + 3'd1;
                end
            end
            ACT_SELECT: begin
                // inverse only when it takes strictly fewer chunks
                r_mvn   <= (r_cnt_a > r_cnt_b);
                r_a     <= r_val;
                r_b     <= r_inv;
                r_first <= 1'b1;
            end
            ACT_EMIT: begin
                if (!hold) begin
                    if (r_mvn) begin
                        r_b <= b_rest;
                    end else begin
                        r_a <= a_rest;
                    end
                    r_first <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid            = r_ovalid;
    assign o_instruction_word = r_oword;
    assign o_last_word        = r_olast;

    a_last_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.act == ACT_EMIT && load_out && out_last) |=> (r_step == ST_FETCH))
        else $error("sequencer did not return to fetch after last word");

    a_emit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_EMIT) |-> ((r_mvn ? r_b : r_a) != 32'd0))
        else $error("emit step with nothing left to emit");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_COUNT || r_step == ST_SELECT) |-> (r_cnt_a <= 3'd4 && r_cnt_b <= 3'd4))
        else $error("chunk count exceeds four");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_SINGLE && load_out) |=> (o_valid && o_last_word))
        else $error("single-word result not marked last");

endmodule

`default_nettype wire

>>> hw/rtl/acs_chunk.sv
`default_nettype none

// Peels the lowest even-aligned byte chunk off a value.
module acs_chunk (
    input  wire logic [31:0] i_value,
    output logic      [7:0]  o_imm8,
    output logic      [3:0]  o_rotf,
    output logic      [31:0] o_rest
);

    logic [4:0]  pos;
    logic [4:0]  p;
    logic [31:0] mask;

    always_comb begin
        pos = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (i_value[i]) begin
                pos = 5'(i);
            end
        end
    end

    assign p      = {pos[4:1], 1'b0};
    assign mask   = 32'h0000_00FF << p;
    assign o_imm8 = 8'(i_value >> p);
    assign o_rotf = 4'd0 - pos[4:1];
    assign o_rest = i_value & ~mask;

endmodule

`default_nettype wire
